FILE: rtl/shbf_pkg.sv
// Shared constants and codes of the single-hash Bloom filter.
`timescale 1ns / 1ps
package shbf_pkg;

    localparam int ADDR_BITS_DEFAULT = 16;

    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 16;
    localparam int IDX_W      = 5;
    localparam int MISS_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [BASE_W-1:0] BASE_RESET  = 16'd33;
    localparam logic [IDX_W-1:0]  INDEX_RESET = 5'd16;
    localparam logic [MISS_W-1:0] MISS_MAX    = '1;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 8'd1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

endpackage

FILE: rtl/shbf_bitmem.sv
// One-bit-wide filter memory with a clearing pass after reset.
`timescale 1ns / 1ps
module shbf_bitmem #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_set_en,
    input  logic [ADDR_BITS-1:0] i_set_addr,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic                 o_rd_data,
    output logic                 o_busy
);
    localparam int DEPTH = 2 ** ADDR_BITS;

    logic                 r_mem [DEPTH];
    logic                 r_rd_data;
    logic                 r_busy;
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;

    assign wr_en   = r_busy | i_set_en;
    assign wr_addr = r_busy ? r_clr_addr : i_set_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= ~r_busy;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

FILE: rtl/single_hash_bloom_filter.sv
// Single-hash Bloom filter over character streams: top level.
// Character beats are taken one per cycle unless the memory is clearing, a result is
// pending or the output is stalled; a tlast beat blocks the input while its result
// is pending. The result passes the filter memory read, then the output register.
// After reset all 2**ADDR_BITS entries are cleared one entry per cycle, during which no
// character is taken; configuration writes are accepted at all times.
`timescale 1ns / 1ps
module single_hash_bloom_filter #(
    parameter int ADDR_BITS = shbf_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [shbf_pkg::CHAR_W-1:0]     i_s_tdata,  // [7:0] word_char
    input  logic                            i_s_tuser,  // [0] func
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [shbf_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [0] word_found, [32:1] miss_count
    output logic                            o_m_tuser,  // [0] was_query
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [shbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [shbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import shbf_pkg::*;

    localparam int PROD_W = ADDR_BITS + BASE_W;

    logic [BASE_W-1:0]    r_base;
    logic [ADDR_BITS-1:0] r_mask;
    logic [ADDR_BITS-1:0] r_hash;
    logic                 r_pend;
    logic                 r_pend_query;
    logic [MISS_W-1:0]    r_miss;
    logic                 r_ovalid;
    logic                 r_ofound;
    logic                 r_oquery;
    logic [MISS_W-1:0]    r_omiss;

    logic [ADDR_BITS-1:0] n_mask;
    logic [MISS_W-1:0]    n_miss;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    sum;
    logic [ADDR_BITS-1:0] hash;
    logic                 in_acc;
    logic                 word_done;
    logic                 found;
    logic                 rd_data;
    logic                 mem_busy;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = ~mem_busy & ~r_pend & (~r_ovalid | i_m_tready);
    assign in_acc      = i_s_tvalid & o_s_tready;
    assign word_done   = in_acc & i_s_tlast;

    assign prod = PROD_W'(r_hash) * PROD_W'(r_base);
    assign sum  = prod + PROD_W'(i_s_tdata);
    assign hash = sum[ADDR_BITS-1:0] & r_mask;

    always_comb begin
        for (int i = 0; i < ADDR_BITS; i++) begin
            n_mask[i] = (IDX_W'(i) < i_cfg_data[IDX_W-1:0]) || (i_cfg_data[IDX_W-1:0] >= IDX_W'(ADDR_BITS));
        end
    end

    assign found = r_pend_query ? rd_data : 1'b1;

    always_comb begin
        n_miss = r_miss;
        if (r_pend && r_pend_query && !rd_data && r_miss != MISS_MAX) begin
            n_miss = r_miss + 1'b1;
        end
    end

    shbf_bitmem #(
        .ADDR_BITS(ADDR_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_set_en   (word_done & (i_s_tuser == FUNC_INSERT)),
        .i_set_addr (hash),
        .i_rd_en    (word_done & (i_s_tuser == FUNC_QUERY)),
        .i_rd_addr  (hash),
        .o_rd_data  (rd_data),
        .o_busy     (mem_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            for (int i = 0; i < ADDR_BITS; i++) begin
                r_mask[i] <= (i < int'(INDEX_RESET));
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HASH_BASE) begin
                r_base <= i_cfg_data[BASE_W-1:0];
            end else if (i_cfg_index == REG_INDEX_BITS) begin
                r_mask <= n_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_pend   <= 1'b0;
            r_miss   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_hash <= i_s_tlast ? '0 : hash;
            end
            r_pend <= word_done;
            r_miss <= n_miss;
            if (r_pend) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_done) begin
            r_pend_query <= i_s_tuser;
        end
        if (r_pend) begin
            r_ofound <= found;
            r_oquery <= r_pend_query;
            r_omiss  <= n_miss;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_oquery;
    assign o_m_tdata  = {{(OUT_DATA_W - MISS_W - 1){1'b0}}, r_omiss, r_ofound};

endmodule
